>>> design/apdf_pkg.sv
// Shared types, register codes, constants and helper functions of the angular density evaluator.
`timescale 1ns / 1ps

package apdf_pkg;

  // Default number of CORDIC rotation steps.
  localparam int ANGLE_BITS_DEF = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_FRACTION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_ASYM         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_IMAG_ASYM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_ASYM_TWO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWAVE_INTERF    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWAVE_FRACTION  = 3'd5;

  // CORDIC start value (inverse gain) in Q2.30.
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  // Reciprocal of three for operands below 2^33, scaled by 2^35.
  localparam logic [33:0] RECIP3 = 34'd11453246123;

  // Event angles carried alongside the azimuth rotation.
  typedef struct packed {
    logic signed [15:0] cos_lepton;
    logic signed [15:0] cos_kaon;
  } evt_t;

  // Physics parameters held in configuration.
  typedef struct packed {
    logic [15:0]        long_fraction;
    logic signed [15:0] forward_backward_asym;
    logic signed [15:0] transverse_imag_asym;
    logic [15:0]        transverse_asym_two;
    logic signed [15:0] swave_interference;
    logic [15:0]        swave_fraction;
  } cfg_t;

  // Arctangent of 2^-i as a fraction of a full turn scaled by 2^32.
  function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
    logic signed [33:0] v;
    unique case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // Floor of a non-negative operand below 2^33 divided by three.
  function automatic logic [31:0] div3_u33(input logic [32:0] u);
    logic [66:0] prod;
    prod = 67'(u) * 67'(RECIP3);
    return prod[66:35];
  endfunction

endpackage

>>> design/apdf_cordic.sv
// Pipelined CORDIC rotator giving cosine and sine of twice the azimuth.
`timescale 1ns / 1ps

module apdf_cordic #(
  parameter int ANGLE_BITS = apdf_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [15:0]         in_code,
  input  apdf_pkg::evt_t      in_evt,
  output logic                out_valid,
  output logic signed [16:0]  out_cos,
  output logic signed [16:0]  out_sin,
  output apdf_pkg::evt_t      out_evt
);

  logic signed [33:0] x_r [ANGLE_BITS+1];
  logic signed [33:0] y_r [ANGLE_BITS+1];
  logic signed [33:0] a_r [ANGLE_BITS+1];
  logic               flip_r [ANGLE_BITS+1];
  apdf_pkg::evt_t     evt_r [ANGLE_BITS+1];
  logic [ANGLE_BITS:0] v_r;

  logic signed [31:0] ang;
  logic signed [33:0] ang_ext;
  logic signed [33:0] ang_fold;
  logic               flip;

  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] xr;
  logic signed [33:0] yr;

  logic               out_valid_r;
  logic signed [16:0] cos_r;
  logic signed [16:0] sin_r;
  apdf_pkg::evt_t     oevt_r;

  // Fold the doubled angle into the right half plane.
  always_comb begin
    ang     = signed'({in_code, 16'b0});
    ang_ext = 34'(ang);
    flip    = 1'b0;
    ang_fold = ang_ext;
    if (ang_ext > 34'sd1073741824) begin
      ang_fold = ang_ext - 34'sd2147483648;
      flip     = 1'b1;
    end else if (ang_ext < -34'sd1073741824) begin
      ang_fold = ang_ext + 34'sd2147483648;
      flip     = 1'b1;
    end
  end

  // Valid bits of the fold stage and the rotation steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[ANGLE_BITS-1:0], in_valid};
      out_valid_r <= v_r[ANGLE_BITS];
    end
  end

  // One micro-rotation per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= apdf_pkg::CORDIC_X0;
      y_r[0]    <= '0;
      a_r[0]    <= ang_fold;
      flip_r[0] <= flip;
      evt_r[0]  <= in_evt;
      for (int i = 0; i < ANGLE_BITS; i++) begin
        if (a_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          a_r[i+1] <= a_r[i] - apdf_pkg::atan_turn(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          a_r[i+1] <= a_r[i] + apdf_pkg::atan_turn(5'(i));
        end
        flip_r[i+1] <= flip_r[i];
        evt_r[i+1]  <= evt_r[i];
      end
    end
  end

  // Undo the fold, round to Q1.15 and clamp to plus or minus one.
  always_comb begin
    xf = flip_r[ANGLE_BITS] ? -x_r[ANGLE_BITS] : x_r[ANGLE_BITS];
    yf = flip_r[ANGLE_BITS] ? -y_r[ANGLE_BITS] : y_r[ANGLE_BITS];
    xr = (xf + 34'sd16384) >>> 15;
    yr = (yf + 34'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oevt_r <= evt_r[ANGLE_BITS];
      if (xr > 34'sd32768) begin
        cos_r <= 17'sd32768;
      end else if (xr < -34'sd32768) begin
        cos_r <= -17'sd32768;
      end else begin
        cos_r <= xr[16:0];
      end
      if (yr > 34'sd32768) begin
        sin_r <= 17'sd32768;
      end else if (yr < -34'sd32768) begin
        sin_r <= -17'sd32768;
      end else begin
        sin_r <= yr[16:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;
  assign out_evt   = oevt_r;

endmodule

>>> design/apdf_math.sv
// Seven-stage fixed-point pipeline that forms the angular density from the angles.
`timescale 1ns / 1ps

module apdf_math (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  apdf_pkg::evt_t     in_evt,
  input  logic signed [16:0] in_cos,
  input  logic signed [16:0] in_sin,
  input  apdf_pkg::cfg_t     cfg,
  output logic               out_valid,
  output logic signed [19:0] out_density
);

  logic [6:0] v_r;

  // Parameters widened to signed form.
  logic signed [17:0] fl;
  logic signed [17:0] omf;
  logic signed [17:0] omfs;
  logic signed [19:0] omf3;
  logic signed [16:0] at2;
  logic signed [16:0] fs;

  // Stage one.
  logic signed [31:0] ck2_r, cl2_r, afbcl_r, asck_r;
  logic signed [34:0] omfat2_r, omfatim_r;
  logic signed [16:0] cp1_r, sp1_r;

  // Stage two.
  logic signed [31:0] sk2, sl2;
  logic signed [32:0] c2l;
  logic signed [63:0] pa_r;
  logic signed [51:0] t1raw_r;
  logic signed [49:0] t2raw_r;
  logic signed [64:0] sc_r, cc_r;
  logic signed [63:0] w6raw_r, s7raw_r;
  logic [48:0]        sfs_r;
  logic signed [34:0] omfat2_2r, omfatim_2r;
  logic signed [16:0] cp2_r, sp2_r;

  // Stage three.
  logic signed [31:0] al, w, a7;
  logic signed [32:0] scr, ccr;
  logic [49:0]        sfs_sum;
  logic [32:0]        u6;
  logic signed [33:0] u6_s;
  logic signed [34:0] t1_r;
  logic signed [32:0] t2_r;
  logic signed [50:0] m3a_r;
  logic signed [50:0] m3b_r;
  logic signed [66:0] x5_r, x7_r;
  logic signed [31:0] w_r, a7_r;
  logic [31:0]        q6_r, ssw_r;
  logic signed [16:0] cp3_r, sp3_r;

  // Stage four.
  logic signed [36:0] r5, r7;
  logic signed [34:0] t3, t4;
  logic signed [33:0] t6;
  logic signed [37:0] pp_r;
  logic signed [53:0] y5_r, y7_r;
  logic signed [33:0] s2_r;

  // Stage five.
  logic signed [38:0] p_r;
  logic signed [33:0] s2_5r;

  // Stage six.
  logic signed [56:0] tp_r;
  logic signed [33:0] s2_6r;

  // Stage seven.
  logic signed [42:0] tot;
  logic signed [28:0] fin;
  logic signed [19:0] dens_r;

  always_comb begin
    fl   = 18'(signed'({1'b0, cfg.long_fraction}));
    omf  = 18'sd32768 - fl;
    omfs = 18'sd32768 - 18'(signed'({1'b0, cfg.swave_fraction}));
    omf3 = 20'(omf) * 20'sd3;
    at2  = signed'({1'b0, cfg.transverse_asym_two});
    fs   = signed'({1'b0, cfg.swave_fraction});
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  // Stage one: squares and parameter products.
  always_ff @(posedge clk) begin
    if (en) begin
      ck2_r     <= 32'(in_evt.cos_kaon) * 32'(in_evt.cos_kaon);
      cl2_r     <= 32'(in_evt.cos_lepton) * 32'(in_evt.cos_lepton);
      afbcl_r   <= 32'(cfg.forward_backward_asym) * 32'(in_evt.cos_lepton);
      asck_r    <= 32'(cfg.swave_interference) * 32'(in_evt.cos_kaon);
      omfat2_r  <= 35'(omf) * 35'(at2);
      omfatim_r <= 35'(omf) * 35'(cfg.transverse_imag_asym);
      cp1_r     <= in_cos;
      sp1_r     <= in_sin;
    end
  end

  // Stage two: sine squares and the raw wide products.
  always_comb begin
    sk2 = 32'sd1073741824 - ck2_r;
    sl2 = 32'sd1073741824 - cl2_r;
    c2l = (33'(cl2_r) <<< 1) - 33'sd1073741824;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r       <= 64'(sk2) * 64'(sl2);
      t1raw_r    <= 52'(omf3) * 52'(sk2);
      t2raw_r    <= 50'(fl) * 50'(ck2_r);
      sc_r       <= 65'(sk2) * 65'(c2l);
      cc_r       <= 65'(ck2_r) * 65'(c2l);
      w6raw_r    <= 64'(sk2) * 64'(afbcl_r);
      s7raw_r    <= 64'(sl2) * 64'(asck_r);
      sfs_r      <= 49'(unsigned'(48'(fs) * 48'(sl2)));
      omfat2_2r  <= omfat2_r;
      omfatim_2r <= omfatim_r;
      cp2_r      <= cp1_r;
      sp2_r      <= sp1_r;
    end
  end

  // Stage three: round to Q30, second products and the divisions by three.
  always_comb begin
    al      = 32'((pa_r + 64'sd536870912) >>> 30);
    scr     = 33'((sc_r + 65'sd536870912) >>> 30);
    ccr     = 33'((cc_r + 65'sd536870912) >>> 30);
    w       = 32'((w6raw_r + 64'sd536870912) >>> 30);
    a7      = 32'((s7raw_r + 64'sd536870912) >>> 30);
    sfs_sum = {sfs_r, 1'b0} + 50'd49152;
    u6_s    = 34'(w) + 34'sd1 + 34'sd6442450944;
    u6      = u6_s[32:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= 35'((t1raw_r + 52'sd65536) >>> 17);
      t2_r  <= 33'((t2raw_r + 50'sd16384) >>> 15);
      m3a_r <= 51'(omf) * 51'(scr);
      m3b_r <= 51'(fl) * 51'(ccr);
      x5_r  <= 67'(omfat2_2r) * 67'(al);
      x7_r  <= 67'(omfatim_2r) * 67'(al);
      w_r   <= w;
      a7_r  <= a7;
      q6_r  <= apdf_pkg::div3_u33(u6);
      ssw_r <= apdf_pkg::div3_u33(sfs_sum[47:15]);
      cp3_r <= cp2_r;
      sp3_r <= sp2_r;
    end
  end

  // Stage four: round the second products, multiply by the trigonometric terms.
  always_comb begin
    t3 = 35'((m3a_r + 51'sd65536) >>> 17);
    t4 = 35'((m3b_r + 51'sd16384) >>> 15);
    r5 = 37'((x5_r + 67'sd536870912) >>> 30);
    r7 = 37'((x7_r + 67'sd536870912) >>> 30);
    t6 = 34'(w_r) + 34'(signed'({2'b0, q6_r})) - 34'sd2147483648;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= 38'(t1_r) + 38'(t2_r) + 38'(t3) - 38'(t4) + 38'(t6);
      y5_r <= 54'(r5) * 54'(cp3_r);
      y7_r <= 54'(r7) * 54'(sp3_r);
      s2_r <= 34'(signed'({2'b0, ssw_r})) + 34'(a7_r);
    end
  end

  // Stage five: complete the P-wave sum.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= 39'(pp_r) + 39'((y5_r + 54'sd32768) >>> 16)
             + 39'((y7_r + 54'sd32768) >>> 16);
      s2_5r <= s2_r;
    end
  end

  // Stage six: scale by one minus the S-wave fraction.
  always_ff @(posedge clk) begin
    if (en) begin
      tp_r  <= 57'(p_r) * 57'(omfs);
      s2_6r <= s2_5r;
    end
  end

  // Stage seven: add the S-wave terms, round to Q16 and saturate.
  always_comb begin
    tot = 43'((tp_r + 57'sd16384) >>> 15) + 43'(s2_6r);
    fin = 29'((tot + 43'sd8192) >>> 14);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin > 29'sd524287) begin
        dens_r <= 20'sd524287;
      end else if (fin < -29'sd524288) begin
        dens_r <= -20'sd524288;
      end else begin
        dens_r <= fin[19:0];
      end
    end
  end

  assign out_valid   = v_r[6];
  assign out_density = dens_r;

endmodule

>>> design/angular_pdf_evaluator.sv
// Top level of the angular density evaluator: configuration registers and pipeline.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_stall     in_cos_lepton, in_cos_kaon, in_azimuth
// out_      output     out_valid / out_stall   out_density
// cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One event is taken every cycle unless the pipeline stalls. Events pass through the
// CORDIC rotator (one stage per step plus fold and rounding) and the seven arithmetic stages.
// Reset clears the valid bits and the configuration registers; payload is not reset.
// A stalled result holds the whole pipeline, and in_stall follows it in the same cycle.
// Configuration writes are always taken.

module angular_pdf_evaluator #(
  parameter int ANGLE_BITS = apdf_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [15:0]                in_cos_lepton,
  input  logic signed [15:0]                in_cos_kaon,
  input  logic [15:0]                       in_azimuth,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [19:0]                out_density,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [apdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);

  apdf_pkg::cfg_t     cfg_r;
  apdf_pkg::evt_t     evt_in;
  apdf_pkg::evt_t     evt_rot;
  logic               en;
  logic               rot_valid;
  logic signed [16:0] rot_cos;
  logic signed [16:0] rot_sin;

  // The pipeline advances unless a finished result is held back.
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        apdf_pkg::REG_LONG_FRACTION:   cfg_r.long_fraction         <= cfg_data;
        apdf_pkg::REG_FB_ASYM:         cfg_r.forward_backward_asym <= cfg_data;
        apdf_pkg::REG_TRANS_IMAG_ASYM: cfg_r.transverse_imag_asym  <= cfg_data;
        apdf_pkg::REG_TRANS_ASYM_TWO:  cfg_r.transverse_asym_two   <= cfg_data;
        apdf_pkg::REG_SWAVE_INTERF:    cfg_r.swave_interference    <= cfg_data;
        apdf_pkg::REG_SWAVE_FRACTION:  cfg_r.swave_fraction        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign evt_in.cos_lepton = in_cos_lepton;
  assign evt_in.cos_kaon   = in_cos_kaon;

  apdf_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_code   (in_azimuth),
    .in_evt    (evt_in),
    .out_valid (rot_valid),
    .out_cos   (rot_cos),
    .out_sin   (rot_sin),
    .out_evt   (evt_rot)
  );

  apdf_math u_math (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (rot_valid),
    .in_evt      (evt_rot),
    .in_cos      (rot_cos),
    .in_sin      (rot_sin),
    .cfg         (cfg_r),
    .out_valid   (out_valid),
    .out_density (out_density)
  );

endmodule

>>> design/apdf_checker.sv
// Port-level checks of the angular density evaluator, bound to the top level.
`timescale 1ns / 1ps

module apdf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [19:0] out_density
);

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_density))
    else $error("held result changed");

  // The input side stalls exactly when a result is held back.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // A result leaves only when taken.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> !$past(out_stall) || !$past(rst_n))
    else $error("result dropped while stalled");

endmodule

bind angular_pdf_evaluator apdf_checker u_apdf_checker (.*);

>>> dv/density_checker.sv
// Checker for the angular density evaluator: watches all channels, predicts and compares results.
`timescale 1ns / 1ps

module density_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [15:0]             in_cos_lepton,
  input  logic signed [15:0]             in_cos_kaon,
  input  logic [15:0]                    in_azimuth,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [19:0]             out_density,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [apdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             checked
);

  localparam int     ROT_STEPS = (apdf_pkg::ANGLE_BITS_DEF > 32) ? 32 : apdf_pkg::ANGLE_BITS_DEF;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint ONE_Q15 = 64'sd32768;
  localparam longint DENS_MAX = 64'sd524287;
  localparam longint DENS_MIN = -64'sd524288;

  // Rotation angles of the CORDIC steps in units of 2^-32 turn.
  localparam longint ROT_ANGLE [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  apdf_pkg::cfg_t      params;
  logic signed [19:0]  density_queue [$];

  // Round half up while dropping s fraction bits.
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Division rounding half up, built on a floor division.
  function automatic longint round_div(longint v, longint d);
    longint n;
    longint m;
    n = 2 * v + d;
    m = 2 * d;
    if (n >= 0) return n / m;
    return -(((-n) + m - 1) / m);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Cosine and sine of twice the azimuth, Q1.15, via a folded CORDIC rotation.
  function automatic void double_azimuth_trig(input logic [15:0] az, output longint c,
                                              output longint s);
    longint a;
    longint x;
    longint y;
    longint nx;
    bit     flip;
    a = longint'(az) <<< 16;
    x = longint'(apdf_pkg::CORDIC_X0);
    y = 0;
    flip = 1'b0;
    if (a >= HALF_TURN) a -= 2 * HALF_TURN;
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a -= ROT_ANGLE[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a += ROT_ANGLE[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(round_shift(x, 15), -ONE_Q15, ONE_Q15);
    s = clip(round_shift(y, 15), -ONE_Q15, ONE_Q15);
  endfunction

  // Expected density of one event under the current parameters.
  function automatic logic signed [19:0] predict_density(logic signed [15:0] cos_l,
                                                         logic signed [15:0] cos_k,
                                                         logic [15:0] az);
    longint cl, ck, fl, at2, fs, afb, atim, as_amp, omf, omfs;
    longint cp, sp, ck2, cl2, sk2, sl2, c2l, al, p, tot;
    cl = longint'(cos_l);
    ck = longint'(cos_k);
    fl = longint'(params.long_fraction);
    at2 = longint'(params.transverse_asym_two);
    fs = longint'(params.swave_fraction);
    afb = longint'(params.forward_backward_asym);
    atim = longint'(params.transverse_imag_asym);
    as_amp = longint'(params.swave_interference);
    omf = ONE_Q15 - fl;
    omfs = ONE_Q15 - fs;
    ck2 = ck * ck;
    cl2 = cl * cl;
    sk2 = ONE_Q30 - ck2;
    sl2 = ONE_Q30 - cl2;
    c2l = 2 * cl2 - ONE_Q30;
    double_azimuth_trig(az, cp, sp);
    al = round_shift(sk2 * sl2, 30);

    // P-wave part in Q30.
    p = round_shift(3 * omf * sk2, 17);
    p += round_shift(fl * ck2, 15);
    p += round_shift(omf * round_shift(sk2 * c2l, 30), 17);
    p -= round_shift(fl * round_shift(ck2 * c2l, 30), 15);
    p += round_shift(round_shift((omf * at2) * al, 30) * cp, 16);
    p += round_div(4 * round_shift(sk2 * (afb * cl), 30), 3);
    p += round_shift(round_shift((omf * atim) * al, 30) * sp, 16);

    // Scale by the P-wave share and add the S-wave terms.
    tot = round_shift(p * omfs, 15);
    tot += round_div(2 * fs * sl2, 3 * ONE_Q15);
    tot += round_shift(sl2 * (as_amp * ck), 30);
    tot = clip(round_shift(tot, 14), DENS_MIN, DENS_MAX);
    return tot[19:0];
  endfunction

  // Track configuration, predict on each input transaction, compare each result.
  always @(posedge clk) begin
    logic signed [19:0] want;
    if (!rst_n) begin
      params <= '0;
      density_queue.delete();
      errors <= 0;
      checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          apdf_pkg::REG_LONG_FRACTION:   params.long_fraction <= cfg_data;
          apdf_pkg::REG_FB_ASYM:         params.forward_backward_asym <= cfg_data;
          apdf_pkg::REG_TRANS_IMAG_ASYM: params.transverse_imag_asym <= cfg_data;
          apdf_pkg::REG_TRANS_ASYM_TWO:  params.transverse_asym_two <= cfg_data;
          apdf_pkg::REG_SWAVE_INTERF:    params.swave_interference <= cfg_data;
          apdf_pkg::REG_SWAVE_FRACTION:  params.swave_fraction <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        density_queue.push_back(predict_density(in_cos_lepton, in_cos_kaon, in_azimuth));
      if (out_valid && !out_stall) begin
        checked <= checked + 1;
        if (density_queue.size() == 0) begin
          $display("%0t: unexpected density result: expected none, actual %0d",
                   $time, out_density);
          errors <= errors + 1;
        end else begin
          want = density_queue.pop_front();
          if (want !== out_density) begin
            $display("%0t: density mismatch: expected %0d, actual %0d",
                     $time, want, out_density);
            errors <= errors + 1;
          end
        end
      end
    end
    pending = density_queue.size();
  end

endmodule

>>> dv/tb.sv
// Testbench top for the angular density evaluator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY = apdf_pkg::ANGLE_BITS_DEF + 9;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD = 4 * LATENCY;
  localparam int RANDOM_PHASES = 8;
  localparam int EVENTS_PER_PHASE = 150;
  // Indexes beyond the register list, which the block ignores.
  localparam logic [apdf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [apdf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [15:0]             in_cos_lepton;
  logic signed [15:0]             in_cos_kaon;
  logic [15:0]                    in_azimuth;
  logic                           out_valid;
  logic                           out_stall;
  logic signed [19:0]             out_density;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [apdf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                    cfg_data;

  int  errors;
  int  pending;
  int  checked;
  int  idle_cycles;
  int  events_sent;
  int  cfg_writes;
  int  hold_left;
  bit  calm;
  bit  hold_req;

  angular_pdf_evaluator uut (.*);

  density_checker chk (.*);

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random stall bursts, one long hold on request, none when calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one register write and hold it until taken; the caller drops valid afterwards.
  task automatic write_reg(input logic [apdf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
  endtask

  // Stop offering events and wait until every expected result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Load all six physics parameters once the pipeline is empty.
  task automatic load_params(input logic [15:0] fl, input logic [15:0] afb,
                             input logic [15:0] atim, input logic [15:0] at2,
                             input logic [15:0] as_amp, input logic [15:0] fs);
    wait_drained();
    write_reg(apdf_pkg::REG_LONG_FRACTION, fl);
    write_reg(apdf_pkg::REG_FB_ASYM, afb);
    write_reg(apdf_pkg::REG_TRANS_IMAG_ASYM, atim);
    write_reg(apdf_pkg::REG_TRANS_ASYM_TWO, at2);
    write_reg(apdf_pkg::REG_SWAVE_INTERF, as_amp);
    write_reg(apdf_pkg::REG_SWAVE_FRACTION, fs);
    cfg_valid <= 1'b0;
  endtask

  // Offer one event and hold it until taken, then maybe leave a short gap.
  task automatic send_event(input logic [15:0] cl, input logic [15:0] ck,
                            input logic [15:0] az);
    in_valid <= 1'b1;
    in_cos_lepton <= cl;
    in_cos_kaon <= ck;
    in_azimuth <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    events_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_cosine();
    logic [15:0] edges [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_azimuth();
    if ($urandom_range(0, 7) == 0)
      return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
    return 16'($urandom);
  endfunction

  // Parameter code: mostly in range, sometimes an extreme code.
  function automatic logic [15:0] pick_param(input bit unsigned_one);
    logic [15:0] edges [5] = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 4)];
    if (unsigned_one) return 16'($urandom_range(0, 32768));
    return 16'($urandom);
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cos_lepton = '0;
    in_cos_kaon = '0;
    in_azimuth = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b1;
    hold_req = 1'b0;
    events_sent = 0;
    cfg_writes = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset parameters, then a Standard Model like point, then field extremes.
    send_event(16'h4000, 16'hC000, 16'h1234);
    load_params(16'd22938, 16'hE000, 16'h0CCD, 16'd9830, 16'hF333, 16'd3277);
    send_event(16'h8000, 16'h8000, 16'h0000);
    send_event(16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_event(16'h0000, 16'h0000, 16'h4000);
    send_event(16'h8000, 16'h7FFF, 16'h8000);
    send_event(16'h7FFF, 16'h8000, 16'hC000);
    send_event(16'hFFFF, 16'h0001, 16'h4001);
    send_event(16'h0001, 16'hFFFF, 16'h3FFF);
    send_event(16'h5A82, 16'hA57E, 16'h2000);
    // Full longitudinal and full S-wave, then raw codes above one.
    load_params(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_event(16'h8000, 16'h4000, 16'h6000);
    send_event(16'h7FFF, 16'hC000, 16'hA000);
    send_event(16'h0000, 16'h7FFF, 16'hE000);
    load_params(16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    send_event(16'h8000, 16'h0000, 16'h0000);
    send_event(16'h0000, 16'h8000, 16'h4000);
    send_event(16'h7FFF, 16'h7FFF, 16'h8000);
    send_event(16'h2000, 16'hE000, 16'hFFFF);
    // Writes to indexes past the list must leave the parameters alone.
    wait_drained();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h1234);
    cfg_valid <= 1'b0;
    send_event(16'h3000, 16'hD000, 16'h9000);
    send_event(16'hD000, 16'h3000, 16'h1000);

    // Random phases with fresh parameters; pressure early, no idling at the end.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_params(pick_param(1'b1), pick_param(1'b0), pick_param(1'b0),
                  pick_param(1'b1), pick_param(1'b0), pick_param(1'b1));
      calm = (ph == 1) || (ph == RANDOM_PHASES - 1);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
        send_event(pick_cosine(), pick_cosine(), pick_azimuth());
        // Sender pause mid-phase until the pipeline has emptied.
        if (ph == 3 && n == EVENTS_PER_PHASE / 2) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);
    $display("Sent %0d events over %0d register writes, %0d densities checked.",
             events_sent, cfg_writes, checked);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/apdf_pkg.sv
design/apdf_cordic.sv
design/apdf_math.sv
design/angular_pdf_evaluator.sv
design/apdf_checker.sv
dv/density_checker.sv
dv/tb.sv
